[rtl/core/assert_macros.svh]
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/core/qtp_pkg.sv]
package qtp_pkg;

  localparam int COORD_WIDTH = 16;

  localparam int IN_W  = 16;
  localparam int PRM_W = 16;
  localparam int SP_W  = IN_W + PRM_W;
  localparam int S_W   = 20;
  localparam int C_W   = 36;
  localparam int P_W   = PRM_W + C_W;
  localparam int T_W   = 54;
  localparam int RT_W  = T_W - 28;
  localparam int R_W   = (COORD_WIDTH >= 28) ? COORD_WIDTH + 1 : 28;

  localparam int IN_TDATA_W  = ((3 * IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION_XY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION_Z  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_WX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_YZ    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_XY       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z        = 3'd5;

  localparam logic [31:0] RST_TRANSLATION_XY = 32'h0000_0000;
  localparam logic [15:0] RST_TRANSLATION_Z  = 16'h0000;
  localparam logic [31:0] RST_ROTATION_WX    = 32'h4000_0000;
  localparam logic [31:0] RST_ROTATION_YZ    = 32'h0000_0000;
  localparam logic [31:0] RST_SCALE_XY       = 32'h1000_1000;
  localparam logic [15:0] RST_SCALE_Z        = 16'h1000;

  localparam logic signed [R_W-1:0] R_HI = R_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [R_W-1:0] R_LO = -R_HI - R_W'(1);

  localparam logic [COORD_WIDTH-1:0] SAT_HI = COORD_WIDTH'(R_HI);
  localparam logic [COORD_WIDTH-1:0] SAT_LO = COORD_WIDTH'(R_LO);

  typedef struct packed {
    logic [COORD_WIDTH-1:0] value;
    logic                   clipped;
  } sat_t;

endpackage

[rtl/core/qtp_saturate.sv]
module qtp_saturate (
  input  logic signed [qtp_pkg::R_W-1:0] r,
  output qtp_pkg::sat_t                  res
);

  always_comb begin
    if (r > qtp_pkg::R_HI) begin
      res.value   = qtp_pkg::SAT_HI;
      res.clipped = 1'b1;
    end else if (r < qtp_pkg::R_LO) begin
      res.value   = qtp_pkg::SAT_LO;
      res.clipped = 1'b1;
    end else begin
      res.value   = r[qtp_pkg::COORD_WIDTH-1:0];
      res.clipped = 1'b0;
    end
  end

endmodule

[rtl/core/quaternion_transform_point.sv]
// Scales, rotates by a unit quaternion and, for points, translates one 3D
// item per clock while m_tready is high. A six-stage pipeline (scale multiply,
// rounding, first cross product, second cross product, combine, round/translate/
// saturate) passes each item from stage to stage up to m_tvalid. Each stage has
// its own valid bit and ready, so bubbles close up; once
// every stage holds an item, a low m_tready drops s_tready in the same cycle.
// op = 1 adds the translation, op = 0 transforms a direction. Results are Q8.8
// saturated to COORD_WIDTH bits; m_tuser flags any saturated coordinate. Write
// the configuration registers only while no item is in flight.
`include "assert_macros.svh"

module quaternion_transform_point (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [qtp_pkg::IN_TDATA_W-1:0]      s_tdata,  // in_x, in_y, in_z
  input  logic                                s_tuser,  // op
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [qtp_pkg::OUT_TDATA_W-1:0]     m_tdata,  // out_x, out_y, out_z
  output logic                                m_tuser,  // overflow
  input  logic                                cfg_we,
  input  logic [qtp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qtp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SP_W  = qtp_pkg::SP_W;
  localparam int S_W   = qtp_pkg::S_W;
  localparam int C_W   = qtp_pkg::C_W;
  localparam int P_W   = qtp_pkg::P_W;
  localparam int T_W   = qtp_pkg::T_W;
  localparam int RT_W  = qtp_pkg::RT_W;
  localparam int R_W   = qtp_pkg::R_W;
  localparam int CW    = qtp_pkg::COORD_WIDTH;
  localparam int IN_W  = qtp_pkg::IN_W;

  // configuration
  logic [31:0] translation_xy;
  logic [15:0] translation_z;
  logic [31:0] rotation_wx;
  logic [31:0] rotation_yz;
  logic [31:0] scale_xy;
  logic [15:0] scale_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      translation_xy <= qtp_pkg::RST_TRANSLATION_XY;
      translation_z  <= qtp_pkg::RST_TRANSLATION_Z;
      rotation_wx    <= qtp_pkg::RST_ROTATION_WX;
      rotation_yz    <= qtp_pkg::RST_ROTATION_YZ;
      scale_xy       <= qtp_pkg::RST_SCALE_XY;
      scale_z        <= qtp_pkg::RST_SCALE_Z;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qtp_pkg::REG_TRANSLATION_XY: translation_xy <= cfg_data;
        qtp_pkg::REG_TRANSLATION_Z:  translation_z  <= cfg_data[15:0];
        qtp_pkg::REG_ROTATION_WX:    rotation_wx    <= cfg_data;
        qtp_pkg::REG_ROTATION_YZ:    rotation_yz    <= cfg_data;
        qtp_pkg::REG_SCALE_XY:       scale_xy       <= cfg_data;
        qtp_pkg::REG_SCALE_Z:        scale_z        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] sc [3];
  logic signed [15:0] tr [3];
  logic signed [15:0] u  [3];
  logic signed [15:0] w;
  logic signed [IN_W-1:0] din [3];

  assign sc[0] = $signed(scale_xy[31:16]);
  assign sc[1] = $signed(scale_xy[15:0]);
  assign sc[2] = $signed(scale_z);
  assign tr[0] = $signed(translation_xy[31:16]);
  assign tr[1] = $signed(translation_xy[15:0]);
  assign tr[2] = $signed(translation_z);
  assign w     = $signed(rotation_wx[31:16]);
  assign u[0]  = $signed(rotation_wx[15:0]);
  assign u[1]  = $signed(rotation_yz[31:16]);
  assign u[2]  = $signed(rotation_yz[15:0]);
  assign din[0] = $signed(s_tdata[IN_W-1:0]);
  assign din[1] = $signed(s_tdata[2*IN_W-1:IN_W]);
  assign din[2] = $signed(s_tdata[3*IN_W-1:2*IN_W]);

  // per-stage valid and ready
  logic [5:0] v;
  logic [5:0] rdy;

  always_comb begin
    rdy[5] = !v[5] || m_tready;
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = v[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= s_tvalid;
      end
      for (int k = 1; k < 6; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 0: scale multiply
  logic signed [SP_W-1:0] p0 [3];
  logic                   op0;

  always_ff @(posedge clk) begin
    if (rdy[0] && s_tvalid) begin
      for (int i = 0; i < 3; i++) begin
        p0[i] <= SP_W'(sc[i]) * SP_W'(din[i]);
      end
      op0 <= s_tuser;
    end
  end

  // stage 1: round to Q.8
  logic signed [SP_W:0]  p0r [3];
  logic signed [S_W-1:0] s1  [3];
  logic                  op1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p0r[i] = (SP_W+1)'(p0[i]) + (SP_W+1)'(2048);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && v[0]) begin
      for (int i = 0; i < 3; i++) begin
        s1[i] <= $signed(p0r[i][S_W+11:12]);
      end
      op1 <= op0;
    end
  end

  // stage 2: c = u x s
  logic signed [C_W-1:0] c2 [3];
  logic signed [S_W-1:0] s2 [3];
  logic                  op2;

  always_ff @(posedge clk) begin
    if (rdy[2] && v[1]) begin
      c2[0] <= C_W'(u[1]) * C_W'(s1[2]) - C_W'(u[2]) * C_W'(s1[1]);
      c2[1] <= C_W'(u[2]) * C_W'(s1[0]) - C_W'(u[0]) * C_W'(s1[2]);
      c2[2] <= C_W'(u[0]) * C_W'(s1[1]) - C_W'(u[1]) * C_W'(s1[0]);
      s2    <= s1;
      op2   <= op1;
    end
  end

  // stage 3: products for w*c and u x c
  logic signed [P_W-1:0] wc3 [3];
  logic signed [P_W-1:0] ua3 [3];
  logic signed [P_W-1:0] ub3 [3];
  logic signed [S_W-1:0] s3  [3];
  logic                  op3;

  always_ff @(posedge clk) begin
    if (rdy[3] && v[2]) begin
      for (int i = 0; i < 3; i++) begin
        wc3[i] <= P_W'(w) * P_W'(c2[i]);
      end
      ua3[0] <= P_W'(u[1]) * P_W'(c2[2]);
      ub3[0] <= P_W'(u[2]) * P_W'(c2[1]);
      ua3[1] <= P_W'(u[2]) * P_W'(c2[0]);
      ub3[1] <= P_W'(u[0]) * P_W'(c2[2]);
      ua3[2] <= P_W'(u[0]) * P_W'(c2[1]);
      ub3[2] <= P_W'(u[1]) * P_W'(c2[0]);
      s3     <= s2;
      op3    <= op2;
    end
  end

  // stage 4: t = 2wc + 2(u x c)
  logic signed [T_W-1:0] t4 [3];
  logic signed [S_W-1:0] s4 [3];
  logic                  op4;

  always_ff @(posedge clk) begin
    if (rdy[4] && v[3]) begin
      for (int i = 0; i < 3; i++) begin
        t4[i] <= (T_W'(wc3[i]) + T_W'(ua3[i]) - T_W'(ub3[i])) <<< 1;
      end
      s4  <= s3;
      op4 <= op3;
    end
  end

  // stage 5: round, add, translate, saturate
  logic signed [T_W-1:0]  t4r [3];
  logic signed [RT_W-1:0] rt  [3];
  logic signed [R_W-1:0]  r5  [3];
  qtp_pkg::sat_t          sat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t4r[i] = t4[i] + T_W'(64'sd1 <<< 27);
      rt[i]  = $signed(t4r[i][T_W-1:28]);
      r5[i]  = R_W'(rt[i]) + R_W'(s4[i]) + (op4 ? R_W'(tr[i]) : R_W'(0));
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_sat
    qtp_saturate u_sat (
      .r   (r5[g]),
      .res (sat[g])
    );
  end

  logic [CW-1:0] ox;
  logic [CW-1:0] oy;
  logic [CW-1:0] oz;
  logic          ovf;

  always_ff @(posedge clk) begin
    if (rdy[5] && v[4]) begin
      ox  <= sat[0].value;
      oy  <= sat[1].value;
      oz  <= sat[2].value;
      ovf <= sat[0].clipped || sat[1].clipped || sat[2].clipped;
    end
  end

  assign m_tdata = qtp_pkg::OUT_TDATA_W'({oz, oy, ox});
  assign m_tuser = ovf;

  // some coordinate sits on a saturation rail
  logic at_rail;

  assign at_rail = (ox == qtp_pkg::SAT_HI) || (ox == qtp_pkg::SAT_LO) ||
                   (oy == qtp_pkg::SAT_HI) || (oy == qtp_pkg::SAT_LO) ||
                   (oz == qtp_pkg::SAT_HI) || (oz == qtp_pkg::SAT_LO);

  `ASSERT_NEXT(a_accept_enters, clk, rst, s_tvalid && s_tready, v[0])
  `ASSERT_IMPL(a_ovf_clipped, clk, rst, m_tvalid && m_tuser, at_rail)
  `ASSERT_NEXT(a_stage_holds, clk, rst, v[4] && !rdy[4], v[4] && $stable(t4[0]) && $stable(op4))

endmodule
